FILE: sv/aes_pkg.sv
// Package: AES-128 types, S-box and round helper functions.
package aes_pkg;

    localparam int unsigned NumRounds = 10;
    localparam int unsigned RndIdxW   = 4;

    typedef logic [127:0] t_block;

    typedef enum logic [0:0] {
        CFG_KEY_HIGH = 1'b0,
        CFG_KEY_LOW  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic   valid;
        t_block state;
    } t_stage;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of the block sits at bits 127-8i .. 120-8i
    function automatic logic [7:0] blk_byte(input t_block b, input int i);
        return b[127 - 8*i -: 8];
    endfunction

    function automatic t_block sub_shift(input t_block s);
        t_block o;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                o[127 - 8*(r + 4*c) -: 8] = sbox(blk_byte(s, r + 4*((c + r) % 4)));
            end
        end
        return o;
    endfunction

    function automatic t_block mix_cols(input t_block s);
        t_block o;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = blk_byte(s, 4*c);
            a1 = blk_byte(s, 4*c + 1);
            a2 = blk_byte(s, 4*c + 2);
            a3 = blk_byte(s, 4*c + 3);
            al = a0 ^ a1 ^ a2 ^ a3;
            o[127 - 32*c -: 8]  = a0 ^ al ^ xtime(a0 ^ a1);
            o[119 - 32*c -: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
            o[111 - 32*c -: 8]  = a2 ^ al ^ xtime(a2 ^ a3);
            o[103 - 32*c -: 8]  = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return o;
    endfunction

    // next round key from the previous one and the round constant
    function automatic t_block next_key(input t_block k, input logic [7:0] rc);
        t_block o;
        logic [31:0] t;
        t = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
        o[127:96] = k[127:96] ^ t;
        o[95:64]  = k[95:64] ^ o[127:96];
        o[63:32]  = k[63:32] ^ o[95:64];
        o[31:0]   = k[31:0] ^ o[63:32];
        return o;
    endfunction

    function automatic logic [7:0] rcon(input logic [RndIdxW-1:0] rnd);
        logic [7:0] r;
        case (rnd)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/aes_stream_if.sv
// Interface: valid/ready channel carrying one 128-bit block as two halves.
interface aes_stream_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;

    modport source (output valid, output data_high, output data_low, input ready);
    modport sink   (input valid, input data_high, input data_low, output ready);
endinterface

FILE: sv/aes_round_cell.sv
// Round cell: one AES round on the state, passing state and round key on.
module aes_round_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [aes_pkg::RndIdxW-1:0] i_rnd,
    input  aes_pkg::t_stage        i_stage,
    input  aes_pkg::t_block        i_key,
    output aes_pkg::t_stage        o_stage,
    output aes_pkg::t_block        o_key
);
    import aes_pkg::*;

    t_block n_key;
    t_block n_state;
    t_block w_ss;
    logic   r_valid;
    t_block r_state;
    t_block r_key;

    always_comb begin
        n_key   = next_key(i_key, rcon(i_rnd));
        w_ss    = sub_shift(i_stage.state);
        if (i_rnd == RndIdxW'(NumRounds)) begin
            n_state = w_ss ^ n_key;
        end else begin
            n_state = mix_cols(w_ss) ^ n_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.valid;
        end
        if (i_en) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_stage = '{valid: r_valid, state: r_state};
    assign o_key   = r_key;
endmodule

FILE: sv/aes128_block_encrypt_core.sv
// Top level: pipelined AES-128 encryption core, one round cell per round.
// Input channel s_in carries plaintext halves, m_out carries ciphertext halves.
// The key is written on the config port: index 0 key_high, index 1 key_low.
// Each accepted item enters an input register that applies the initial key
// addition, then passes through ten round cells, one round per cell per cycle.
// The round key travels beside the data, so each item uses the key that was
// set when it was accepted.
// Throughput: one item per cycle unless m_out stalls (eleven-register cell chain).
// The whole chain advances together; when m_out is stalled and the last
// cell holds an item, the chain freezes and s_in.ready drops. Empty slots
// inside the chain are not squeezed out: the chain moves only when its
// last register is empty or being taken.
// Reset clears all valid flags and both key registers to zero.
module aes128_block_encrypt_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    aes_stream_if.sink   s_in,
    aes_stream_if.source m_out
);
    import aes_pkg::*;

    logic [63:0] r_key_high;
    logic [63:0] r_key_low;
    logic        w_en;
    logic        r_v0;
    t_block      r_s0;
    t_block      r_k0;

    t_stage w_stage [0:NumRounds];
    t_block w_key   [0:NumRounds];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en       = !w_stage[NumRounds].valid || m_out.ready;
    assign s_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= s_in.valid;
        end
        if (w_en) begin
            r_s0 <= {s_in.data_high, s_in.data_low} ^ {r_key_high, r_key_low};
            r_k0 <= {r_key_high, r_key_low};
        end
    end

    assign w_stage[0] = '{valid: r_v0, state: r_s0};
    assign w_key[0]   = r_k0;

    for (genvar g = 1; g <= NumRounds; g++) begin : g_cell
        aes_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_rnd   (RndIdxW'(g)),
            .i_stage (w_stage[g-1]),
            .i_key   (w_key[g-1]),
            .o_stage (w_stage[g]),
            .o_key   (w_key[g])
        );
    end

    assign m_out.valid     = w_stage[NumRounds].valid;
    assign m_out.data_high = w_stage[NumRounds].state[127:64];
    assign m_out.data_low  = w_stage[NumRounds].state[63:0];
endmodule

FILE: tb/tb_aes_stream_if.sv
// Testbench clock generator: free-running 4 ns clock.
`timescale 1ns / 100ps
module tb_aes_clk_gen (
    output logic o_clk
);
    initial begin
        o_clk = 1'b0;
        forever #2 o_clk = ~o_clk;
    end
endmodule

FILE: tb/tb_aes128_block_encrypt_core.sv
// Testbench: AES-128 core checked against an in-bench cipher model with random flow control.
`timescale 1ns / 100ps
module tb_aes128_block_encrypt_core;
    import aes_pkg::*;

    localparam int Latency    = 11;
    localparam int CycleLimit = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    aes_stream_if s_in ();
    aes_stream_if m_out ();

    tb_aes_clk_gen u_clk (.o_clk(i_clk));

    aes128_block_encrypt_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (s_in.sink),
        .m_out      (m_out.source)
    );

    logic [127:0] cipher_q[$];
    logic [127:0] key_model;
    int  errors;
    int  cycles;
    bit  src_idle_en;
    bit  sink_idle_en;
    int  sink_hold;
    int  stall_req;
    int  stall_seen;

    logic [7:0] sb_tab[256];

    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] byte_at(input logic [127:0] b, input int i);
        return b[127 - 8*i -: 8];
    endfunction

    function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                                 input logic [127:0] pt);
        logic [127:0] rk, s, o;
        logic [31:0]  t;
        logic [7:0]   rc, a0, a1, a2, a3, al;
        rk = key;
        rc = 8'h01;
        s  = pt ^ rk;
        for (int rnd = 1; rnd <= 10; rnd++) begin
            t = {sb_tab[rk[23:16]] ^ rc, sb_tab[rk[15:8]], sb_tab[rk[7:0]],
                 sb_tab[rk[31:24]]};
            rk[127:96] = rk[127:96] ^ t;
            rk[95:64]  = rk[95:64] ^ rk[127:96];
            rk[63:32]  = rk[63:32] ^ rk[95:64];
            rk[31:0]   = rk[31:0] ^ rk[63:32];
            rc = gf_dbl(rc);
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    o[127 - 8*(r + 4*c) -: 8] = sb_tab[byte_at(s, r + 4*((c + r) & 3))];
            s = o;
            if (rnd < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = byte_at(s, 4*c);
                    a1 = byte_at(s, 4*c + 1);
                    a2 = byte_at(s, 4*c + 2);
                    a3 = byte_at(s, 4*c + 3);
                    al = a0 ^ a1 ^ a2 ^ a3;
                    o[127 - 32*c -: 8] = a0 ^ al ^ gf_dbl(a0 ^ a1);
                    o[119 - 32*c -: 8] = a1 ^ al ^ gf_dbl(a1 ^ a2);
                    o[111 - 32*c -: 8] = a2 ^ al ^ gf_dbl(a2 ^ a3);
                    o[103 - 32*c -: 8] = a3 ^ al ^ gf_dbl(a3 ^ a0);
                end
                s = o;
            end
            s = s ^ rk;
        end
        return s;
    endfunction

    // sbox built from GF inverse and affine map
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = gf_dbl(a);
        end
        return p;
    endfunction

    initial begin
        logic [7:0] inv, x;
        for (int a = 0; a < 256; a++) begin
            inv = 8'h00;
            for (int b = 1; b < 256; b++)
                if (gf_mul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
            x = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sb_tab[a] = x;
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // sink: random ready, long hold when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_hold   <= 0;
            m_out.ready <= 1'b0;
        end else if (stall_req != stall_seen) begin
            stall_seen  <= stall_req;
            sink_hold   <= 59;
            m_out.ready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold   <= sink_hold - 1;
            m_out.ready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
            sink_hold   <= $urandom_range(0, 15);
            m_out.ready <= 1'b0;
        end else begin
            m_out.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        logic [127:0] exp_blk, got;
        if (i_rst_n && m_out.valid && m_out.ready) begin
            got = {m_out.data_high, m_out.data_low};
            if (cipher_q.size() == 0) begin
                $display("%0t: unexpected item, expected none actual %h", $time, got);
                errors++;
            end else begin
                exp_blk = cipher_q.pop_front();
                if (got[127:64] !== exp_blk[127:64]) begin
                    $display("%0t: cipher_high expected %h actual %h", $time,
                             exp_blk[127:64], got[127:64]);
                    errors++;
                end
                if (got[63:0] !== exp_blk[63:0]) begin
                    $display("%0t: cipher_low expected %h actual %h", $time,
                             exp_blk[63:0], got[63:0]);
                    errors++;
                end
            end
        end
    end

    task automatic send_block(input logic [127:0] pt);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            s_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_in.valid     <= 1'b1;
        s_in.data_high <= pt[127:64];
        s_in.data_low  <= pt[63:0];
        do @(posedge i_clk); while (!s_in.ready);
        cipher_q.push_back(aes_encrypt(key_model, pt));
    endtask

    task automatic drain();
        s_in.valid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (Latency + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_KEY_HIGH) key_model[127:64] = val;
        else                     key_model[63:0]   = val;
    endtask

    task automatic set_key(input logic [127:0] k);
        drain();
        write_reg(CFG_KEY_HIGH, k[127:64]);
        write_reg(CFG_KEY_LOW, k[63:0]);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [127:0] rand_blk();
        return {$urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    task automatic test_reset_key();
        send_block('0);
        send_block('1);
    endtask

    task automatic test_known_vector();
        set_key(128'h000102030405060708090a0b0c0d0e0f);
        send_block(128'h00112233445566778899aabbccddeeff);
        set_key(128'h2b7e151628aed2a6abf7158809cf4f3c);
        send_block(128'h3243f6a8885a308d313198a2e0370734);
    endtask

    task automatic test_extremes();
        set_key('1);
        send_block('0);
        send_block('1);
        send_block(128'h80000000000000000000000000000001);
        send_block({64'h0, 64'hffffffffffffffff});
        send_block({64'hffffffffffffffff, 64'h0});
        set_key('0);
        send_block(128'haaaaaaaaaaaaaaaa5555555555555555);
        for (int i = 0; i < 8; i++) send_block(128'h1 << (i * 16 + $urandom_range(0, 15)));
        set_key({64'h0, 64'hffffffffffffffff});
        send_block(rand_blk());
    endtask

    task automatic test_backpressure();
        src_idle_en = 1'b0;
        set_key(rand_blk());
        stall_req++;
        for (int i = 0; i < 30; i++) send_block(rand_blk());
        drain();
        src_idle_en = 1'b1;
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 10; ph++) begin
            set_key(rand_blk());
            for (int i = 0; i < 46; i++) send_block(rand_blk());
        end
    endtask

    task automatic test_no_idle();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        set_key(rand_blk());
        for (int i = 0; i < 40; i++) send_block(rand_blk());
    endtask

    initial begin
        errors       = 0;
        stall_req    = 0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        key_model    = '0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_KEY_HIGH;
        i_cfg_data   = '0;
        s_in.valid     = 1'b0;
        s_in.data_high = '0;
        s_in.data_low  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_key();
        test_known_vector();
        test_extremes();
        test_backpressure();
        test_random();
        test_no_idle();
        drain();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
